### rtl/avt_pkg.sv
// Shared constants and types for the affine vertex transform.
package avt_pkg;

   // Parameter defaults
   localparam int COORD_WIDTH_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 12;

   // Coefficient field and register layout
   localparam int COEF_W      = 16;
   localparam int ROW_W       = 3 * COEF_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   // Register indexes on the configuration channel
   localparam logic [CSR_INDEX_W-1:0] REG_MATRIX_ROW0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MATRIX_ROW1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MATRIX_ROW2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_AXIS_SCALE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SHIFT_X       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SHIFT_Y       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SHIFT_Z       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TRANSFORM_MODE = 3'd7;

   // Transform modes; the reserved code acts as identity
   localparam logic [1:0] MODE_GENERAL   = 2'd0;
   localparam logic [1:0] MODE_ROT_SCALE = 2'd1;
   localparam logic [1:0] MODE_IDENTITY  = 2'd2;
   localparam logic [1:0] MODE_RESERVED  = 2'd3;

   // Coefficient set handed from the register file to the datapath
   typedef struct packed {
      logic [2:0][ROW_W-1:0] row;
      logic [ROW_W-1:0]      scale;
      logic [1:0]            mode;
   } avt_coef_type;

endpackage

### rtl/avt_pipe.sv
// Five-stage transform datapath: scale, round, matrix products, sums, translate.
module avt_pipe #(
   parameter int COORD_WIDTH    = avt_pkg::COORD_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = avt_pkg::COEF_FRAC_BITS_DEF,
   parameter int TDATA_W        = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  avt_pkg::avt_coef_type        coef,
   input  logic [2:0][COORD_WIDTH-1:0]  shift,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [TDATA_W-1:0]           req_tdata,
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [TDATA_W-1:0]           rsp_tdata,
   output logic                         rsp_tuser
);
   import avt_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int PW = CW + COEF_W;      // one coefficient product
   localparam int SW = CW + COEF_W + 3;  // sum of three products plus rounding

   localparam logic signed [PW:0] RND_P = {{PW{1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
   localparam logic signed [SW-1:0] RND_S = {{(SW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
   localparam logic signed [PW:0] PMAX = {{(PW-CW+2){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [PW:0] PMIN = {{(PW-CW+2){1'b1}}, {(CW-1){1'b0}}};
   localparam logic signed [SW-1:0] SMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   // Stage enables: a stage advances when empty or when the next one advances
   logic en1, en2, en3, en4, en5;

   // Stage 1: scale products
   logic                   p1_valid_ff, p1_point_ff;
   logic [1:0]             p1_mode_ff;
   logic signed [CW-1:0]   p1_raw_ff  [3];
   logic signed [PW-1:0]   p1_prod_ff [3];
   logic signed [PW-1:0]   p1_prod_in [3];

   // Stage 2: rounded and saturated scaled vector
   logic                   p2_valid_ff, p2_point_ff, p2_ovf_ff;
   logic [1:0]             p2_mode_ff;
   logic signed [CW-1:0]   p2_v_ff [3];
   logic signed [CW-1:0]   p2_v_in [3];
   logic                   p2_ovf_in;

   // Stage 3: matrix products
   logic                   p3_valid_ff, p3_point_ff, p3_ovf_ff;
   logic [1:0]             p3_mode_ff;
   logic signed [CW-1:0]   p3_v_ff [3];
   logic signed [PW-1:0]   p3_prod_ff [3][3];
   logic signed [PW-1:0]   p3_prod_in [3][3];

   // Stage 4: row sums with rounding constant
   logic                   p4_valid_ff, p4_point_ff, p4_ovf_ff;
   logic [1:0]             p4_mode_ff;
   logic signed [CW-1:0]   p4_v_ff [3];
   logic signed [SW-1:0]   p4_sum_ff [3];
   logic signed [SW-1:0]   p4_sum_in [3];

   // Stage 5: output register
   logic                   p5_valid_ff, p5_ovf_ff;
   logic signed [CW-1:0]   p5_out_ff [3];
   logic signed [CW-1:0]   p5_out_in [3];
   logic                   p5_ovf_in;

   assign en5 = !p5_valid_ff || rsp_tready;
   assign en4 = !p4_valid_ff || en5;
   assign en3 = !p3_valid_ff || en4;
   assign en2 = !p2_valid_ff || en3;
   assign en1 = !p1_valid_ff || en2;
   assign req_tready = en1;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
      end else begin
         if (en1) p1_valid_ff <= req_tvalid;
         if (en2) p2_valid_ff <= p1_valid_ff;
         if (en3) p3_valid_ff <= p2_valid_ff;
         if (en4) p4_valid_ff <= p3_valid_ff;
         if (en5) p5_valid_ff <= p4_valid_ff;
      end
   end

   // Stage 1: multiply each input component by its axis scale
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_prod_in[i] = $signed(req_tdata[i*CW +: CW]) *
                         $signed(coef.scale[i*COEF_W +: COEF_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         p1_point_ff <= !req_tuser;
         p1_mode_ff  <= coef.mode;
         for (int i = 0; i < 3; i++) begin
            p1_raw_ff[i]  <= $signed(req_tdata[i*CW +: CW]);
            p1_prod_ff[i] <= p1_prod_in[i];
         end
      end
   end

   // Stage 2: round and saturate the scaled vector in rotation-scale mode
   always_comb begin
      logic signed [PW:0] rnd;
      p2_ovf_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         rnd = ((PW+1)'(p1_prod_ff[i]) + RND_P) >>> COEF_FRAC_BITS;
         if (p1_mode_ff != MODE_ROT_SCALE) begin
            p2_v_in[i] = p1_raw_ff[i];
         end else if (rnd > PMAX) begin
            p2_v_in[i] = PMAX[CW-1:0];
            p2_ovf_in  = 1'b1;
         end else if (rnd < PMIN) begin
            p2_v_in[i] = PMIN[CW-1:0];
            p2_ovf_in  = 1'b1;
         end else begin
            p2_v_in[i] = rnd[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         p2_point_ff <= p1_point_ff;
         p2_mode_ff  <= p1_mode_ff;
         p2_ovf_ff   <= p2_ovf_in;
         for (int i = 0; i < 3; i++) p2_v_ff[i] <= p2_v_in[i];
      end
   end

   // Stage 3: nine matrix products
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p3_prod_in[r][c] = $signed(coef.row[r][c*COEF_W +: COEF_W]) * p2_v_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         p3_point_ff <= p2_point_ff;
         p3_mode_ff  <= p2_mode_ff;
         p3_ovf_ff   <= p2_ovf_ff;
         for (int r = 0; r < 3; r++) begin
            p3_v_ff[r] <= p2_v_ff[r];
            for (int c = 0; c < 3; c++) p3_prod_ff[r][c] <= p3_prod_in[r][c];
         end
      end
   end

   // Stage 4: add each row with the rounding constant
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         p4_sum_in[r] = SW'(p3_prod_ff[r][0]) + SW'(p3_prod_ff[r][1]) +
                        SW'(p3_prod_ff[r][2]) + RND_S;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         p4_point_ff <= p3_point_ff;
         p4_mode_ff  <= p3_mode_ff;
         p4_ovf_ff   <= p3_ovf_ff;
         for (int r = 0; r < 3; r++) begin
            p4_v_ff[r]   <= p3_v_ff[r];
            p4_sum_ff[r] <= p4_sum_in[r];
         end
      end
   end

   // Stage 5: drop fraction bits, add translation for points, saturate; identity modes pass the vector through
   always_comb begin
      logic signed [SW-1:0] acc;
      logic                 ident;
      ident     = (p4_mode_ff == MODE_IDENTITY) || (p4_mode_ff == MODE_RESERVED);
      p5_ovf_in = p4_ovf_ff;
      for (int r = 0; r < 3; r++) begin
         acc = p4_sum_ff[r] >>> COEF_FRAC_BITS;
         if (p4_point_ff) acc = acc + SW'($signed(shift[r]));
         if (ident) begin
            p5_out_in[r] = p4_v_ff[r];
         end else if (acc > SMAX) begin
            p5_out_in[r] = SMAX[CW-1:0];
            p5_ovf_in    = 1'b1;
         end else if (acc < SMIN) begin
            p5_out_in[r] = SMIN[CW-1:0];
            p5_ovf_in    = 1'b1;
         end else begin
            p5_out_in[r] = acc[CW-1:0];
         end
      end
      if (ident) p5_ovf_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         p5_ovf_ff <= p5_ovf_in;
         for (int r = 0; r < 3; r++) p5_out_ff[r] <= p5_out_in[r];
      end
   end

   // Pack the result transfer
   always_comb begin
      rsp_tdata = '0;
      for (int r = 0; r < 3; r++) rsp_tdata[r*CW +: CW] = p5_out_ff[r];
   end

   assign rsp_tvalid = p5_valid_ff;
   assign rsp_tuser  = p5_ovf_ff;

endmodule

### rtl/affine_vertex_transform.sv
// Top level of the affine vertex transform: register file, datapath, checks.
//
// Transforms one 3D point or direction per transfer by a configured affine
// transform (identity, rotation with per-axis scale, or general 3x3 matrix).
// req channel: tdata carries x, y, z as signed Q16.8 (x lowest); tuser is 1
// for a direction (no translation) and 0 for a point.
// rsp channel: tdata carries the transformed x, y, z (x lowest); tuser is
// the overflow flag, set when any component saturated.
// csr channel: csr_index selects the register (row0..row2, axis scale,
// shift x/y/z, mode), csr_data carries it; csr_ready is always high.
// Write registers only while no item is in flight.
// Five register stages: scale, round, matrix products, row sums, output.
// Throughput: one item per cycle while the receiver does not stall, set by
// the fully pipelined multipliers.
// Reset clears all stage valid bits and loads the identity transform.
// When the receiver stalls, stages fill up toward the input; req_tready
// drops only once the stage in front of the input is also held.
module affine_vertex_transform #(
   parameter int COORD_WIDTH    = avt_pkg::COORD_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = avt_pkg::COEF_FRAC_BITS_DEF,
   parameter int TDATA_W        = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [avt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [avt_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [TDATA_W-1:0]               req_tdata,  // in_x, in_y, in_z
   input  logic                             req_tuser,  // operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [TDATA_W-1:0]               rsp_tdata,  // out_x, out_y, out_z
   output logic                             rsp_tuser   // overflow
);
   import avt_pkg::*;

   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(33'd1 << COEF_FRAC_BITS);

   logic [2:0][ROW_W-1:0]        row_ff;
   logic [ROW_W-1:0]             scale_ff;
   logic [2:0][COORD_WIDTH-1:0]  shift_ff;
   logic [1:0]                   mode_ff;
   avt_coef_type                 coef;

   assign csr_ready = 1'b1;

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= {{(2*COEF_W){1'b0}}, COEF_ONE};
         row_ff[1] <= {{COEF_W{1'b0}}, COEF_ONE, {COEF_W{1'b0}}};
         row_ff[2] <= {COEF_ONE, {(2*COEF_W){1'b0}}};
         scale_ff  <= {3{COEF_ONE}};
         shift_ff  <= '0;
         mode_ff   <= MODE_IDENTITY;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MATRIX_ROW0:    row_ff[0]   <= csr_data[ROW_W-1:0];
            REG_MATRIX_ROW1:    row_ff[1]   <= csr_data[ROW_W-1:0];
            REG_MATRIX_ROW2:    row_ff[2]   <= csr_data[ROW_W-1:0];
            REG_AXIS_SCALE:     scale_ff    <= csr_data[ROW_W-1:0];
            REG_SHIFT_X:        shift_ff[0] <= csr_data[COORD_WIDTH-1:0];
            REG_SHIFT_Y:        shift_ff[1] <= csr_data[COORD_WIDTH-1:0];
            REG_SHIFT_Z:        shift_ff[2] <= csr_data[COORD_WIDTH-1:0];
            REG_TRANSFORM_MODE: mode_ff     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   assign coef.row   = row_ff;
   assign coef.scale = scale_ff;
   assign coef.mode  = mode_ff;

   avt_pipe #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .TDATA_W        (TDATA_W)
   ) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef),
      .shift      (shift_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // An empty output stage never holds back the input
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output stage");

   // A result leaving frees the whole pipeline
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |-> req_tready)
      else $error("input stalled while output transfer completes");

   // Reset empties the output stage
   assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

### tb/tb_affine_vertex_transform.sv
// Self-checking testbench for the affine vertex transform: directed and random vertex streams.
module tb_affine_vertex_transform;
   import avt_pkg::*;

   localparam int CW            = COORD_WIDTH_DEF;
   localparam int FRAC          = COEF_FRAC_BITS_DEF;
   localparam int TDATA_W       = ((3 * CW + 7) / 8) * 8;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 100;

   // Operation codes carried on req_tuser
   localparam logic OP_POINT     = 1'b0;
   localparam logic OP_DIRECTION = 1'b1;

   localparam logic [CW-1:0]     COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0]     COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1 << FRAC);
   localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(1 << (FRAC - 1));
   localparam logic [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic [COEF_W-1:0] COEF_ZERO = '0;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
      logic          ovf;
   } vertex_out_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [TDATA_W-1:0]     req_tdata;  // in_x, in_y, in_z
   logic                   req_tuser;  // operation
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [TDATA_W-1:0]     rsp_tdata;  // out_x, out_y, out_z
   logic                   rsp_tuser;  // overflow

   // Mirror of the block's registers, updated on each csr transfer
   logic [ROW_W-1:0] cfg_row [3];
   logic [ROW_W-1:0] cfg_scale;
   logic [CW-1:0]    cfg_shift [3];
   logic [1:0]       cfg_mode;

   vertex_out_type expected_vertices [$];
   int          mismatch_count  = 0;
   int          idle_cycles     = 0;
   int          items_accepted  = 0;
   int          results_checked = 0;
   int          overflow_seen   = 0;
   int          csr_writes      = 0;
   bit          steady          = 1'b0;

   affine_vertex_transform DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic longint coef_field(logic [ROW_W-1:0] packed_row, int col);
      logic signed [COEF_W-1:0] f;
      f = packed_row[col*COEF_W +: COEF_W];
      return longint'(f);
   endfunction

   // Round to nearest with ties toward plus infinity, dropping the coefficient fraction
   function automatic longint round_half_up(longint v);
      return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint clamp_coord(longint v, inout logic ovf);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         ovf = 1'b1;
         return hi;
      end
      if (v < lo) begin
         ovf = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic vertex_out_type transform_vertex(logic op, logic [CW-1:0] ix,
                                                       logic [CW-1:0] iy, logic [CW-1:0] iz);
      longint         v [3];
      longint         res [3];
      longint         acc;
      logic           ovf;
      int             i;
      int             c;
      vertex_out_type r;
      v[0] = longint'(signed'(ix));
      v[1] = longint'(signed'(iy));
      v[2] = longint'(signed'(iz));
      ovf  = 1'b0;
      if (cfg_mode == MODE_GENERAL || cfg_mode == MODE_ROT_SCALE) begin
         // Scale each axis first, clamping the intermediate
         if (cfg_mode == MODE_ROT_SCALE) begin
            for (i = 0; i < 3; i++)
               v[i] = clamp_coord(round_half_up(v[i] * coef_field(cfg_scale, i)), ovf);
         end
         for (i = 0; i < 3; i++) begin
            acc = 0;
            for (c = 0; c < 3; c++)
               acc += coef_field(cfg_row[i], c) * v[c];
            acc = round_half_up(acc);
            if (op == OP_POINT)
               acc += longint'(signed'(cfg_shift[i]));
            res[i] = clamp_coord(acc, ovf);
         end
      end else begin
         // Identity and the reserved mode pass the vector through
         for (i = 0; i < 3; i++)
            res[i] = v[i];
      end
      r.x   = res[0][CW-1:0];
      r.y   = res[1][CW-1:0];
      r.z   = res[2][CW-1:0];
      r.ovf = ovf;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      $display("%0t: ERROR %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      vertex_out_type want;
      vertex_out_type got;
      bit             moved;
      moved = 1'b0;
      if (reset) begin
         cfg_row[0]  = ROW_W'(COEF_ONE);
         cfg_row[1]  = ROW_W'(COEF_ONE) << COEF_W;
         cfg_row[2]  = ROW_W'(COEF_ONE) << (2 * COEF_W);
         cfg_scale   = {COEF_ONE, COEF_ONE, COEF_ONE};
         cfg_shift[0] = '0;
         cfg_shift[1] = '0;
         cfg_shift[2] = '0;
         cfg_mode    = MODE_IDENTITY;
         idle_cycles = 0;
      end else begin
         // Track register writes
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            csr_writes++;
            case (csr_index)
               REG_MATRIX_ROW0:    cfg_row[0]   = csr_data;
               REG_MATRIX_ROW1:    cfg_row[1]   = csr_data;
               REG_MATRIX_ROW2:    cfg_row[2]   = csr_data;
               REG_AXIS_SCALE:     cfg_scale    = csr_data;
               REG_SHIFT_X:        cfg_shift[0] = csr_data[CW-1:0];
               REG_SHIFT_Y:        cfg_shift[1] = csr_data[CW-1:0];
               REG_SHIFT_Z:        cfg_shift[2] = csr_data[CW-1:0];
               REG_TRANSFORM_MODE: cfg_mode     = csr_data[1:0];
               default: ;
            endcase
         end
         // Predict each accepted vertex
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            items_accepted++;
            expected_vertices.push_back(transform_vertex(req_tuser, req_tdata[CW-1:0],
                                                         req_tdata[2*CW-1:CW],
                                                         req_tdata[3*CW-1:2*CW]));
         end
         // Compare each result transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            moved   = 1'b1;
            got.x   = rsp_tdata[CW-1:0];
            got.y   = rsp_tdata[2*CW-1:CW];
            got.z   = rsp_tdata[3*CW-1:2*CW];
            got.ovf = rsp_tuser;
            if (got.ovf === 1'b1)
               overflow_seen++;
            if (expected_vertices.size() == 0) begin
               report_mismatch($sformatf("result %h/%h/%h with no vertex pending",
                                         got.x, got.y, got.z));
            end else begin
               want = expected_vertices.pop_front();
               if (got.x !== want.x)
                  report_mismatch($sformatf("result %0d out_x %h, expected %h",
                                            results_checked, got.x, want.x));
               if (got.y !== want.y)
                  report_mismatch($sformatf("result %0d out_y %h, expected %h",
                                            results_checked, got.y, want.y));
               if (got.z !== want.z)
                  report_mismatch($sformatf("result %0d out_z %h, expected %h",
                                            results_checked, got.z, want.z));
               if (got.ovf !== want.ovf)
                  report_mismatch($sformatf("result %0d overflow %b, expected %b",
                                            results_checked, got.ovf, want.ovf));
            end
            results_checked++;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   // End the run when no transfer of any kind happens for too long
   initial begin
      wait (!reset);
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus helpers

   // Mostly no gap, sometimes a short one, rarely a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Receiver: stall at random, hold ready high during steady phases
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (steady) begin
            rsp_tready = 1'b1;
            @(negedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready = 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_tready = 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   function automatic logic [CW-1:0] random_coord();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10)
         return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      if (roll < 55)
         return CW'(int'($urandom_range(0, 65535)) - 32768);
      if (roll < 75)
         return CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      return CW'($urandom);
   endfunction

   function automatic logic [COEF_W-1:0] random_coef();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         case ($urandom_range(0, 4))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return COEF_ZERO;
            3:       return COEF_ONE;
            default: return -COEF_ONE;
         endcase
      end
      if (roll < 50)
         return COEF_W'(int'($urandom_range(0, 16383)) - 8192);
      if (roll < 70)
         return COEF_W'(int'($urandom_range(0, 2047)) - 1024);
      return COEF_W'($urandom);
   endfunction

   function automatic logic [ROW_W-1:0] coef_row(logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
                                                  logic [COEF_W-1:0] c2);
      return {c2, c1, c0};
   endfunction

   // Drive one register write and hold until the transfer
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Drive one vertex after a random gap and hold until the transfer
   task automatic send_vertex(logic op, logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
      int gap;
      gap       = pick_gap();
      csr_valid = 1'b0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = TDATA_W'({z, y, x});
      req_tuser  = op;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Wait until every predicted result has come back and the pipeline is empty
   task automatic drain_pipeline();
      req_tvalid = 1'b0;
      csr_valid  = 1'b0;
      while (expected_vertices.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   // Reset transform: identity mode, then identity matrix and unit scale
   task automatic test_reset_transform();
      send_vertex(OP_POINT, COORD_MAX, COORD_MIN, CW'(1));
      send_vertex(OP_DIRECTION, COORD_MIN, COORD_MAX, CW'(-1));
      drain_pipeline();
      write_csr(REG_TRANSFORM_MODE, CSR_DATA_W'(MODE_GENERAL));
      send_vertex(OP_POINT, CW'(24'h123456), CW'(-5), COORD_MAX);
      drain_pipeline();
      write_csr(REG_TRANSFORM_MODE, CSR_DATA_W'(MODE_ROT_SCALE));
      send_vertex(OP_DIRECTION, CW'(-1), CW'(1), CW'(24'h400000));
      drain_pipeline();
   endtask

   // Translation at its extremes: points get it, directions do not
   task automatic test_translation();
      write_csr(REG_SHIFT_X, CSR_DATA_W'(COORD_MAX));
      write_csr(REG_SHIFT_Y, CSR_DATA_W'(COORD_MIN));
      write_csr(REG_SHIFT_Z, CSR_DATA_W'(CW'(24'h000100)));
      write_csr(REG_TRANSFORM_MODE, CSR_DATA_W'(MODE_GENERAL));
      send_vertex(OP_POINT, COORD_MAX, COORD_MIN, CW'(0));
      send_vertex(OP_DIRECTION, COORD_MAX, COORD_MIN, CW'(0));
      send_vertex(OP_POINT, CW'(0), CW'(0), CW'(0));
      drain_pipeline();
   endtask

   // Half coefficients put products exactly on rounding ties
   task automatic test_rounding_ties();
      write_csr(REG_MATRIX_ROW0, coef_row(COEF_HALF, COEF_ZERO, COEF_ZERO));
      write_csr(REG_MATRIX_ROW1, coef_row(COEF_ZERO, COEF_HALF, COEF_ZERO));
      write_csr(REG_MATRIX_ROW2, coef_row(COEF_ZERO, COEF_ZERO, COEF_HALF));
      send_vertex(OP_DIRECTION, CW'(1), CW'(-1), CW'(3));
      send_vertex(OP_DIRECTION, CW'(-3), CW'(5), CW'(-5));
      drain_pipeline();
   endtask

   // Largest and most negative coefficients against extreme inputs
   task automatic test_matrix_extremes();
      write_csr(REG_MATRIX_ROW0, coef_row(COEF_MAX, COEF_MAX, COEF_MAX));
      write_csr(REG_MATRIX_ROW1, coef_row(COEF_MAX, COEF_MAX, COEF_MAX));
      write_csr(REG_MATRIX_ROW2, coef_row(COEF_MAX, COEF_MAX, COEF_MAX));
      send_vertex(OP_DIRECTION, COORD_MAX, COORD_MAX, COORD_MAX);
      send_vertex(OP_DIRECTION, COORD_MIN, COORD_MIN, COORD_MIN);
      drain_pipeline();
      write_csr(REG_MATRIX_ROW0, coef_row(COEF_MIN, COEF_MIN, COEF_MIN));
      write_csr(REG_MATRIX_ROW1, coef_row(COEF_MIN, COEF_MIN, COEF_MIN));
      write_csr(REG_MATRIX_ROW2, coef_row(COEF_MIN, COEF_MIN, COEF_MIN));
      send_vertex(OP_DIRECTION, COORD_MIN, COORD_MIN, COORD_MIN);
      send_vertex(OP_DIRECTION, COORD_MAX, COORD_MIN, COORD_MAX);
      drain_pipeline();
   endtask

   // Saturated scaled intermediate must flag overflow even when the matrix zeroes it
   task automatic test_scale_saturation();
      write_csr(REG_MATRIX_ROW0, '0);
      write_csr(REG_MATRIX_ROW1, '0);
      write_csr(REG_MATRIX_ROW2, '0);
      write_csr(REG_AXIS_SCALE, coef_row(COEF_MAX, COEF_MAX, COEF_MAX));
      write_csr(REG_TRANSFORM_MODE, CSR_DATA_W'(MODE_ROT_SCALE));
      send_vertex(OP_DIRECTION, COORD_MAX, CW'(1), CW'(0));
      send_vertex(OP_POINT, CW'(24'h100), CW'(24'h100), CW'(24'h100));
      drain_pipeline();
      write_csr(REG_AXIS_SCALE, coef_row(COEF_MIN, COEF_MIN, COEF_MIN));
      send_vertex(OP_DIRECTION, COORD_MIN, CW'(0), CW'(0));
      drain_pipeline();
   endtask

   // Reserved mode code acts as identity; upper data bits are ignored
   task automatic test_reserved_mode();
      write_csr(REG_TRANSFORM_MODE, {(CSR_DATA_W-2)'('1), MODE_RESERVED});
      send_vertex(OP_POINT, CW'(1), CW'(2), CW'(3));
      send_vertex(OP_DIRECTION, random_coord(), random_coord(), random_coord());
      drain_pipeline();
   endtask

   // Random configurations, each followed by a burst of random vertices
   task automatic test_random_stream();
      int          phase;
      int          n;
      int          r;
      int          roll;
      logic [1:0]  mode;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady = (phase % 3 == 1);
         for (r = 0; r < 3; r++) begin
            if ($urandom_range(0, 3) != 0)
               write_csr(CSR_INDEX_W'(REG_MATRIX_ROW0 + r),
                         coef_row(random_coef(), random_coef(), random_coef()));
         end
         if ($urandom_range(0, 3) != 0)
            write_csr(REG_AXIS_SCALE, coef_row(random_coef(), random_coef(), random_coef()));
         for (r = 0; r < 3; r++) begin
            if ($urandom_range(0, 2) != 0)
               write_csr(CSR_INDEX_W'(REG_SHIFT_X + r),
                         {(CSR_DATA_W-CW)'($urandom), random_coord()});
         end
         roll = $urandom_range(0, 99);
         if (roll < 40)
            mode = MODE_GENERAL;
         else if (roll < 80)
            mode = MODE_ROT_SCALE;
         else if (roll < 90)
            mode = MODE_IDENTITY;
         else
            mode = MODE_RESERVED;
         write_csr(REG_TRANSFORM_MODE, {$urandom, (CSR_DATA_W-34)'($urandom), mode});
         for (n = 0; n < PHASE_ITEMS; n++)
            send_vertex(logic'($urandom_range(0, 1)), random_coord(), random_coord(),
                        random_coord());
         drain_pipeline();
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_POINT;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_transform();
      test_translation();
      test_rounding_ties();
      test_matrix_extremes();
      test_scale_saturation();
      test_reserved_mode();
      test_random_stream();
      drain_pipeline();

      $display("Covered every transform mode, points and directions, rounding ties, clamping");
      $display("%0d vertices, %0d results (%0d saturated), %0d register writes, %0d errors",
               items_accepted, results_checked, overflow_seen, csr_writes, mismatch_count);
      if (mismatch_count == 0 && expected_vertices.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
